// ===== sv/tia_pkg.sv =====
// Package for the typed integer ALU: payload structs, op and fault codes and type helpers.
// Used by every module of the block; no dependencies.
package tia_pkg;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_REM  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_OR   = 4'd6;
  localparam logic [3:0] OP_XOR  = 4'd7;
  localparam logic [3:0] OP_SHL  = 4'd8;
  localparam logic [3:0] OP_SHR  = 4'd9;
  localparam logic [3:0] OP_EQ   = 4'd10;
  localparam logic [3:0] OP_NE   = 4'd11;
  localparam logic [3:0] OP_GT   = 4'd12;
  localparam logic [3:0] OP_GE   = 4'd13;
  localparam logic [3:0] OP_CAST = 4'd14;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_DIV0 = 2'd1;
  localparam logic [1:0] FAULT_OVF  = 2'd2;

  localparam int DivSteps = 64;

  typedef struct packed {
    logic [3:0]  op;
    logic [2:0]  operand_type;
    logic [2:0]  dest_type;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
  } in_t;

  typedef struct packed {
    logic [63:0] result;
    logic [1:0]  fault;
  } out_t;

  // Control and data that ride alongside the divider.
  typedef struct packed {
    logic [3:0]  op;
    logic [63:0] mask;
    logic [1:0]  fault;
    logic        neg_q;
    logic        neg_r;
    logic [63:0] res;
  } side_t;

  function automatic logic [63:0] type_mask(input logic [2:0] t);
    logic [63:0] m;
    case (t[1:0])
      2'd0:    m = 64'h0000_0000_0000_00FF;
      2'd1:    m = 64'h0000_0000_0000_FFFF;
      2'd2:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] extend(input logic [63:0] x, input logic [2:0] t);
    logic [63:0] r;
    case (t[1:0])
      2'd0:    r = {{56{x[7]  & ~t[2]}}, x[7:0]};
      2'd1:    r = {{48{x[15] & ~t[2]}}, x[15:0]};
      2'd2:    r = {{32{x[31] & ~t[2]}}, x[31:0]};
      default: r = x;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/tia_exec.sv =====
// Two-stage front end: operand extension, simple ops, split 64-bit multiply,
// division magnitudes and fault detection. Depends on tia_pkg.
module tia_exec (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  tia_pkg::in_t      req,
  output logic              out_valid,
  output tia_pkg::side_t    side,
  output logic [63:0]       ma,
  output logic [63:0]       mb
);

  logic [63:0] a, b, m, sh, mag_a, mag_b;
  logic [6:0]  w;
  logic        sgn, big, na, nb, ovf;
  tia_pkg::side_t s;

  always_comb begin
    sgn   = ~req.operand_type[2];
    m     = tia_pkg::type_mask(req.operand_type);
    a     = tia_pkg::extend(req.operand_a, req.operand_type);
    b     = tia_pkg::extend(req.operand_b, req.operand_type);
    sh    = req.operand_b & m;
    w     = 7'd8 << req.operand_type[1:0];
    big   = (sh[63:7] != 57'd0) || (sh[6:0] >= w);
    na    = sgn & a[63];
    nb    = sgn & b[63];
    mag_a = na ? (64'd0 - a) : a;
    mag_b = nb ? (64'd0 - b) : b;
    ovf   = sgn && (b == '1) && (a == ~(m >> 1));
    s.op    = req.op;
    s.mask  = m;
    s.fault = tia_pkg::FAULT_NONE;
    s.neg_q = na ^ nb;
    s.neg_r = na;
    s.res   = '0;
    case (req.op)
      tia_pkg::OP_ADD: s.res = a + b;
      tia_pkg::OP_SUB: s.res = a - b;
      tia_pkg::OP_DIV, tia_pkg::OP_REM: begin
        if (b == 64'd0) begin
          s.fault = tia_pkg::FAULT_DIV0;
        end else if (ovf) begin
          s.fault = tia_pkg::FAULT_OVF;
          s.res   = (req.op == tia_pkg::OP_DIV) ? a : 64'd0;
        end
      end
      tia_pkg::OP_AND: s.res = a & b;
      tia_pkg::OP_OR:  s.res = a | b;
      tia_pkg::OP_XOR: s.res = a ^ b;
      tia_pkg::OP_SHL: s.res = big ? 64'd0 : (a << sh[5:0]);
      tia_pkg::OP_SHR: begin
        if (na) s.res = big ? '1 : 64'($signed(a) >>> sh[5:0]);
        else    s.res = big ? 64'd0 : (a >> sh[5:0]);
      end
      tia_pkg::OP_EQ: s.res = {63'd0, a == b};
      tia_pkg::OP_NE: s.res = {63'd0, a != b};
      tia_pkg::OP_GT: s.res = {63'd0, (a ^ {sgn, 63'd0}) >  (b ^ {sgn, 63'd0})};
      tia_pkg::OP_GE: s.res = {63'd0, (a ^ {sgn, 63'd0}) >= (b ^ {sgn, 63'd0})};
      tia_pkg::OP_CAST: begin
        s.mask = tia_pkg::type_mask(req.dest_type);
        s.res  = a;
      end
      default: s.res = '0;
    endcase
  end

  // stage A: partial products of the low 64 bits of a*b
  logic           va;
  tia_pkg::side_t sa;
  tia_pkg::side_t side_next;
  logic [63:0]    ma_a, mb_a, p0;
  logic [31:0]    p1, p2;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else     va <= in_valid;
    sa   <= s;
    ma_a <= mag_a;
    mb_a <= mag_b;
    p0   <= a[31:0] * b[31:0];
    p1   <= 32'(a[31:0] * b[63:32]);
    p2   <= 32'(a[63:32] * b[31:0]);
  end

  // stage B: combine partial products
  always_comb begin
    side_next = sa;
    if (sa.op == tia_pkg::OP_MUL) side_next.res = p0 + {p1 + p2, 32'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= va;
    side <= side_next;
    ma <= ma_a;
    mb <= mb_a;
  end

endmodule

// ===== sv/tia_div_step.sv =====
// One registered restoring-division step: one quotient bit per stage.
// Depends on tia_pkg.
module tia_div_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  tia_pkg::side_t in_side,
  input  logic [63:0]    in_rem,
  input  logic [63:0]    in_quo,
  input  logic [63:0]    in_dvs,
  output logic           out_valid,
  output tia_pkg::side_t out_side,
  output logic [63:0]    out_rem,
  output logic [63:0]    out_quo,
  output logic [63:0]    out_dvs
);

  logic [64:0] t;

  assign t = {in_rem, in_quo[63]} - {1'b0, in_dvs};

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= in_valid;
    out_side <= in_side;
    out_dvs  <= in_dvs;
    out_quo  <= {in_quo[62:0], ~t[64]};
    out_rem  <= t[64] ? {in_rem[62:0], in_quo[63]} : t[63:0];
  end

endmodule

// ===== sv/tia_div.sv =====
// 64-stage pipelined unsigned divider carrying the side payload.
// Depends on tia_pkg and tia_div_step.
module tia_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  tia_pkg::side_t in_side,
  input  logic [63:0]    dividend,
  input  logic [63:0]    divisor,
  output logic           out_valid,
  output tia_pkg::side_t out_side,
  output logic [63:0]    quotient,
  output logic [63:0]    remainder
);

  localparam int N = tia_pkg::DivSteps;

  logic           v   [N+1];
  tia_pkg::side_t sd  [N+1];
  logic [63:0]    rem [N+1];
  logic [63:0]    quo [N+1];
  logic [63:0]    dvs [N+1];

  assign v[0]   = in_valid;
  assign sd[0]  = in_side;
  assign rem[0] = 64'd0;
  assign quo[0] = dividend;
  assign dvs[0] = divisor;

  for (genvar i = 0; i < N; i++) begin : g_step
    tia_div_step u_step (
      .clk(clk), .rst(rst),
      .in_valid(v[i]), .in_side(sd[i]), .in_rem(rem[i]), .in_quo(quo[i]),
      .in_dvs(dvs[i]),
      .out_valid(v[i+1]), .out_side(sd[i+1]), .out_rem(rem[i+1]),
      .out_quo(quo[i+1]), .out_dvs(dvs[i+1])
    );
  end

  assign out_valid = v[N];
  assign out_side  = sd[N];
  assign quotient  = quo[N];
  assign remainder = rem[N];

endmodule

// ===== sv/typed_integer_alu_core.sv =====
// Top level of the typed integer ALU: input register, front end, divider, result.
// Depends on tia_pkg, tia_exec and tia_div.
//
// Usage: drive request and raise start; the command transfers at a rising edge
// with start high and busy low. busy is never raised, so a new command may
// transfer in every cycle. Every command gives one response, shown on response
// for exactly one cycle with done high, in command order.
// Every operation passes through one input register, two front-end
// stages (the 64-bit multiply is split into 32-bit partial products), 64
// divider stages (one quotient bit per stage, which sets the depth) and one
// output register. Non-divide results ride through the divider stages so that
// all ops share one latency. Throughput is one command per cycle.
// Synchronous reset clears all valid bits; commands in flight are dropped and
// no response follows reset. The receiver cannot stall: a response is taken in
// the cycle it is shown.
module typed_integer_alu_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  tia_pkg::in_t  request,
  output logic          done,
  output tia_pkg::out_t response
);

  logic           v0;
  tia_pkg::in_t   req0;
  logic           v1, v2;
  tia_pkg::side_t s1, s2;
  logic [63:0]    ma, mb, q, r, fix;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= start & ~busy;
    req0 <= request;
  end

  tia_exec u_exec (
    .clk(clk), .rst(rst), .in_valid(v0), .req(req0),
    .out_valid(v1), .side(s1), .ma(ma), .mb(mb)
  );

  tia_div u_div (
    .clk(clk), .rst(rst), .in_valid(v1), .in_side(s1),
    .dividend(ma), .divisor(mb),
    .out_valid(v2), .out_side(s2), .quotient(q), .remainder(r)
  );

  always_comb begin
    fix = s2.res;
    if (s2.fault == tia_pkg::FAULT_NONE) begin
      if (s2.op == tia_pkg::OP_DIV)      fix = s2.neg_q ? (64'd0 - q) : q;
      else if (s2.op == tia_pkg::OP_REM) fix = s2.neg_r ? (64'd0 - r) : r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v2;
    response <= '{result: fix & s2.mask, fault: s2.fault};
  end

endmodule
